// ===== hdl/wphu_pkg.sv =====
// ----------------------------------------------------------------------------
// wphu_pkg
// Shared types and constants for the wall presence hysteresis unit.
// ----------------------------------------------------------------------------
package wphu_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_FRONT_DETECT = 3'd0,
    REG_FRONT_CLEAR  = 3'd1,
    REG_SIDE_DETECT  = 3'd2,
    REG_SIDE_CLEAR   = 3'd3,
    REG_INVALID_RUN  = 3'd4
  } wphu_reg_e;

  localparam logic [15:0] FRONT_DETECT_RST = 16'd115;
  localparam logic [15:0] FRONT_CLEAR_RST  = 16'd135;
  localparam logic [15:0] SIDE_DETECT_RST  = 16'd108;
  localparam logic [15:0] SIDE_CLEAR_RST   = 16'd122;
  localparam logic [3:0]  INVALID_RUN_RST  = 4'd2;

  localparam logic signed [16:0] SKEW_MAX = 17'sd32767;
  localparam logic signed [16:0] SKEW_MIN = -17'sd32768;

  typedef struct packed {
    logic        sensors_ready;
    logic [15:0] front_left_distance;
    logic [15:0] front_right_distance;
    logic [15:0] left_side_distance;
    logic [15:0] right_side_distance;
    logic        front_left_ok;
    logic        front_right_ok;
    logic        left_side_ok;
    logic        right_side_ok;
  } wphu_in_t;

  typedef struct packed {
    logic               wall_left;
    logic               wall_front;
    logic               wall_right;
    logic               left_reading_valid;
    logic               front_reading_valid;
    logic               right_reading_valid;
    logic signed [15:0] front_skew_mm;
  } wphu_out_t;

  typedef struct packed {
    logic [15:0] front_detect_mm;
    logic [15:0] front_clear_mm;
    logic [15:0] side_detect_mm;
    logic [15:0] side_clear_mm;
    logic [3:0]  invalid_run_to_clear;
  } wphu_cfg_t;

  typedef struct packed {
    logic               left_flag;
    logic               front_flag;
    logic               right_flag;
    logic [2:0]         valid_marks;
    logic [3:0]         left_invalid_run;
    logic [3:0]         right_invalid_run;
    logic [3:0]         front_invalid_run;
    logic signed [15:0] skew_hold;
  } wphu_state_t;

endpackage

// ===== hdl/wphu_cfg.sv =====
// ----------------------------------------------------------------------------
// wphu_cfg
// Threshold and run length registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module wphu_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wphu_pkg::ADDR_W-1:0] paddr,
  input  logic [wphu_pkg::DATA_W-1:0] pwdata,
  output logic [wphu_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output wphu_pkg::wphu_cfg_t        cfg
);
  import wphu_pkg::*;

  wphu_reg_e reg_sel;
  logic      wr_en;

  assign reg_sel = wphu_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.front_detect_mm      <= FRONT_DETECT_RST;
      cfg.front_clear_mm       <= FRONT_CLEAR_RST;
      cfg.side_detect_mm       <= SIDE_DETECT_RST;
      cfg.side_clear_mm        <= SIDE_CLEAR_RST;
      cfg.invalid_run_to_clear <= INVALID_RUN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FRONT_DETECT: cfg.front_detect_mm      <= pwdata[15:0];
        REG_FRONT_CLEAR:  cfg.front_clear_mm       <= pwdata[15:0];
        REG_SIDE_DETECT:  cfg.side_detect_mm       <= pwdata[15:0];
        REG_SIDE_CLEAR:   cfg.side_clear_mm        <= pwdata[15:0];
        REG_INVALID_RUN:  cfg.invalid_run_to_clear <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRONT_DETECT: prdata = DATA_W'(cfg.front_detect_mm);
      REG_FRONT_CLEAR:  prdata = DATA_W'(cfg.front_clear_mm);
      REG_SIDE_DETECT:  prdata = DATA_W'(cfg.side_detect_mm);
      REG_SIDE_CLEAR:   prdata = DATA_W'(cfg.side_clear_mm);
      REG_INVALID_RUN:  prdata = DATA_W'(cfg.invalid_run_to_clear);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/wphu_track.sv =====
// ----------------------------------------------------------------------------
// wphu_track
// Wall flag state with detect/clear hysteresis, invalid run counters and
// the held forward skew.
// ----------------------------------------------------------------------------
module wphu_track #(
  parameter int DIST_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  wphu_pkg::wphu_in_t    item,
  input  wphu_pkg::wphu_cfg_t   cfg,
  output wphu_pkg::wphu_state_t state,
  output wphu_pkg::wphu_state_t state_next
);
  import wphu_pkg::*;

  logic [15:0]        fl, fr, ls, rs;
  logic               f_any, f_both;
  logic               det, clr;
  logic [4:0]         left_cnt, right_cnt, front_cnt;
  logic signed [16:0] diff;
  wphu_state_t        upd;

  // returns {force open, new run count}
  function automatic logic [4:0] count_run(input logic [3:0] run, input logic [3:0] thr);
    logic [3:0] r;
    r = run;
    if (r < thr) begin
      r = r + 4'd1;
    end
    return {(r >= thr), r};
  endfunction

  assign fl = 16'(item.front_left_distance[DIST_WIDTH-1:0]);
  assign fr = 16'(item.front_right_distance[DIST_WIDTH-1:0]);
  assign ls = 16'(item.left_side_distance[DIST_WIDTH-1:0]);
  assign rs = 16'(item.right_side_distance[DIST_WIDTH-1:0]);

  assign f_any  = item.front_left_ok || item.front_right_ok;
  assign f_both = item.front_left_ok && item.front_right_ok;

  assign left_cnt  = count_run(state.left_invalid_run, cfg.invalid_run_to_clear);
  assign right_cnt = count_run(state.right_invalid_run, cfg.invalid_run_to_clear);
  assign front_cnt = count_run(state.front_invalid_run, cfg.invalid_run_to_clear);

  assign diff = $signed({1'b0, fl}) - $signed({1'b0, fr});

  always_comb begin
    priority if (f_both) begin
      det = (fl <= cfg.front_detect_mm) && (fr <= cfg.front_detect_mm);
      clr = (fl >= cfg.front_clear_mm) && (fr >= cfg.front_clear_mm);
    end else if (item.front_left_ok) begin
      det = fl <= cfg.front_detect_mm;
      clr = fl >= cfg.front_clear_mm;
    end else begin
      det = fr <= cfg.front_detect_mm;
      clr = fr >= cfg.front_clear_mm;
    end
  end

  always_comb begin
    upd = state;
    upd.valid_marks = {item.right_side_ok, f_any, item.left_side_ok};

    if (item.left_side_ok) begin
      upd.left_invalid_run = '0;
      upd.left_flag = state.left_flag ? (ls < cfg.side_clear_mm) : (ls <= cfg.side_detect_mm);
    end else begin
      upd.left_invalid_run = left_cnt[3:0];
      upd.left_flag = left_cnt[4] ? 1'b0 : state.left_flag;
    end

    if (item.right_side_ok) begin
      upd.right_invalid_run = '0;
      upd.right_flag = state.right_flag ? (rs < cfg.side_clear_mm) : (rs <= cfg.side_detect_mm);
    end else begin
      upd.right_invalid_run = right_cnt[3:0];
      upd.right_flag = right_cnt[4] ? 1'b0 : state.right_flag;
    end

    if (f_any) begin
      upd.front_invalid_run = '0;
      priority if (!state.front_flag && det) begin
        upd.front_flag = 1'b1;
      end else if (state.front_flag && clr) begin
        upd.front_flag = 1'b0;
      end else begin
        upd.front_flag = state.front_flag;
      end
    end else begin
      upd.front_invalid_run = front_cnt[3:0];
      if (front_cnt[4]) begin
        upd.front_flag = 1'b0;
      end
    end

    if (f_both) begin
      priority if (diff > SKEW_MAX) begin
        upd.skew_hold = SKEW_MAX[15:0];
      end else if (diff < SKEW_MIN) begin
        upd.skew_hold = SKEW_MIN[15:0];
      end else begin
        upd.skew_hold = diff[15:0];
      end
    end
  end

  assign state_next = (update && item.sensors_ready) ? upd : state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/wall_presence_hysteresis_unit.sv =====
// ----------------------------------------------------------------------------
// wall_presence_hysteresis_unit
// Left, front and right wall detection with hysteresis from range readings.
// ----------------------------------------------------------------------------
// One sensor set is taken per clock while the output side keeps taking results,
// and each set gives one result: the wall flags, valid marks and held forward
// skew after that set. A set goes into an input register, the state update runs
// once the result register is free, and the result register loads with it, so a
// result is offered from the result register, behind the input register.
module wall_presence_hysteresis_unit #(
  parameter int DIST_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wphu_pkg::wphu_in_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wphu_pkg::wphu_out_t         out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wphu_pkg::ADDR_W-1:0] paddr,
  input  logic [wphu_pkg::DATA_W-1:0] pwdata,
  output logic [wphu_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import wphu_pkg::*;

  logic        s0_valid;
  wphu_in_t    s0_item;
  logic        advance;
  wphu_cfg_t   cfg;
  wphu_state_t state, state_next;

  assign advance  = s0_valid && (!out_valid || out_ready);
  assign in_ready = !s0_valid || advance;

  wphu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wphu_track #(
    .DIST_WIDTH (DIST_WIDTH)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .item       (s0_item),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.wall_left           <= state_next.left_flag;
      out_item.wall_front          <= state_next.front_flag;
      out_item.wall_right          <= state_next.right_flag;
      out_item.left_reading_valid  <= state_next.valid_marks[0];
      out_item.front_reading_valid <= state_next.valid_marks[1];
      out_item.right_reading_valid <= state_next.valid_marks[2];
      out_item.front_skew_mm       <= state_next.skew_hold;
    end
  end

`ifndef NO_ASSERTIONS
  // state moves only when a set with sensors ready leaves the input register
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !(advance && s0_item.sensors_ready) |=> $stable(state))
    else $error("state changed without a ready sensor set");

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.wall_left == state.left_flag) &&
                  (out_item.wall_front == state.front_flag) &&
                  (out_item.wall_right == state.right_flag) &&
                  (out_item.front_skew_mm == state.skew_hold))
    else $error("pending result differs from tracked state");

  a_front_mark_run: assert property (@(posedge clk) disable iff (rst)
    state.valid_marks[1] |-> (state.front_invalid_run == 4'd0))
    else $error("front run count nonzero after a valid forward reading");

  a_left_mark_run: assert property (@(posedge clk) disable iff (rst)
    state.valid_marks[0] |-> (state.left_invalid_run == 4'd0))
    else $error("left run count nonzero after a valid side reading");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s0_valid |-> in_ready)
    else $error("input stalled with empty input register");
`endif

endmodule

// ===== tb/wphu_checker.sv =====
// ----------------------------------------------------------------------------
// wphu_checker
// Watches the sensor, result and register ports of the wall presence unit,
// keeps its own copy of the wall state and register settings, and compares
// each result transfer, field by field, with the oldest expected result.
// Register reads are compared with the settings last written.
// ----------------------------------------------------------------------------
module wphu_checker
  import wphu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  wphu_in_t            in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  wphu_out_t           out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic [DATA_W-1:0]   prdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  pending,
  output int                  checked,
  output int                  flag_changes
);
  timeunit 1ns;
  timeprecision 1ps;

  wphu_cfg_t          cfg;
  logic               left_wall, front_wall, right_wall;
  logic [2:0]         marks;
  logic [3:0]         left_run, right_run, front_run;
  logic signed [15:0] skew;
  wphu_out_t          expected_walls[$];
  wphu_out_t          want;

  initial begin
    mismatches = 0;
    pending = 0;
    checked = 0;
    flag_changes = 0;
  end

  task automatic note_field(input string what, input logic [31:0] want_v,
                            input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s at %0t: expected %0h, got %0h", what, $realtime,
                 want_v, got_v);
      end
    end
  endtask

  function automatic logic [3:0] bump_run(input logic [3:0] run);
    return (run < cfg.invalid_run_to_clear) ? run + 4'd1 : run;
  endfunction

  task automatic side_step(input logic ok, input logic [15:0] range_mm,
                           inout logic wall, inout logic [3:0] run);
    if (!ok) begin
      run = bump_run(run);
      if (run >= cfg.invalid_run_to_clear) wall = 1'b0;
    end else begin
      run = '0;
      wall = wall ? (range_mm < cfg.side_clear_mm) : (range_mm <= cfg.side_detect_mm);
    end
  endtask

  task automatic predict_walls(input wphu_in_t s);
    logic               both, any_front, det, clr;
    logic [2:0]         walls_before;
    logic signed [16:0] diff;
    wphu_out_t          r;
    walls_before = {left_wall, front_wall, right_wall};
    if (s.sensors_ready) begin
      any_front = s.front_left_ok | s.front_right_ok;
      both = s.front_left_ok & s.front_right_ok;
      marks = {s.right_side_ok, any_front, s.left_side_ok};
      side_step(s.left_side_ok, s.left_side_distance, left_wall, left_run);
      side_step(s.right_side_ok, s.right_side_distance, right_wall, right_run);
      if (any_front) begin
        front_run = '0;
        if (both) begin
          det = s.front_left_distance <= cfg.front_detect_mm &&
                s.front_right_distance <= cfg.front_detect_mm;
          clr = s.front_left_distance >= cfg.front_clear_mm &&
                s.front_right_distance >= cfg.front_clear_mm;
        end else if (s.front_left_ok) begin
          det = s.front_left_distance <= cfg.front_detect_mm;
          clr = s.front_left_distance >= cfg.front_clear_mm;
        end else begin
          det = s.front_right_distance <= cfg.front_detect_mm;
          clr = s.front_right_distance >= cfg.front_clear_mm;
        end
        if (!front_wall && det) begin
          front_wall = 1'b1;
        end else if (front_wall && clr) begin
          front_wall = 1'b0;
        end
      end else begin
        front_run = bump_run(front_run);
        if (front_run >= cfg.invalid_run_to_clear) front_wall = 1'b0;
      end
      if (both) begin
        diff = $signed({1'b0, s.front_left_distance}) -
               $signed({1'b0, s.front_right_distance});
        if (diff > SKEW_MAX) begin
          skew = SKEW_MAX[15:0];
        end else if (diff < SKEW_MIN) begin
          skew = SKEW_MIN[15:0];
        end else begin
          skew = diff[15:0];
        end
      end
    end
    flag_changes += $countones(walls_before ^ {left_wall, front_wall, right_wall});
    r.wall_left = left_wall;
    r.wall_front = front_wall;
    r.wall_right = right_wall;
    r.left_reading_valid = marks[0];
    r.front_reading_valid = marks[1];
    r.right_reading_valid = marks[2];
    r.front_skew_mm = skew;
    expected_walls.push_back(r);
  endtask

  function automatic logic [31:0] reg_value(input logic [ADDR_W-1:0] addr);
    case (wphu_reg_e'(addr[4:2]))
      REG_FRONT_DETECT: return {16'd0, cfg.front_detect_mm};
      REG_FRONT_CLEAR:  return {16'd0, cfg.front_clear_mm};
      REG_SIDE_DETECT:  return {16'd0, cfg.side_detect_mm};
      REG_SIDE_CLEAR:   return {16'd0, cfg.side_clear_mm};
      REG_INVALID_RUN:  return {28'd0, cfg.invalid_run_to_clear};
      default:          return 32'd0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.front_detect_mm <= FRONT_DETECT_RST;
      cfg.front_clear_mm <= FRONT_CLEAR_RST;
      cfg.side_detect_mm <= SIDE_DETECT_RST;
      cfg.side_clear_mm <= SIDE_CLEAR_RST;
      cfg.invalid_run_to_clear <= INVALID_RUN_RST;
      left_wall <= 1'b0;
      front_wall <= 1'b0;
      right_wall <= 1'b0;
      marks <= '0;
      left_run <= '0;
      right_run <= '0;
      front_run <= '0;
      skew <= '0;
      expected_walls.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (wphu_reg_e'(paddr[4:2]))
            REG_FRONT_DETECT: cfg.front_detect_mm = pwdata[15:0];
            REG_FRONT_CLEAR:  cfg.front_clear_mm = pwdata[15:0];
            REG_SIDE_DETECT:  cfg.side_detect_mm = pwdata[15:0];
            REG_SIDE_CLEAR:   cfg.side_clear_mm = pwdata[15:0];
            REG_INVALID_RUN:  cfg.invalid_run_to_clear = pwdata[3:0];
            default: ;
          endcase
        end else begin
          note_field("register read", reg_value(paddr), prdata);
        end
      end
      if (in_valid && in_ready) predict_walls(in_item);
      if (out_valid && out_ready) begin
        if (expected_walls.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result transfer at %0t with none expected", $realtime);
        end else begin
          want = expected_walls.pop_front();
          note_field("wall_left", want.wall_left, out_item.wall_left);
          note_field("wall_front", want.wall_front, out_item.wall_front);
          note_field("wall_right", want.wall_right, out_item.wall_right);
          note_field("left_reading_valid", want.left_reading_valid,
                     out_item.left_reading_valid);
          note_field("front_reading_valid", want.front_reading_valid,
                     out_item.front_reading_valid);
          note_field("right_reading_valid", want.right_reading_valid,
                     out_item.right_reading_valid);
          note_field("front_skew_mm", {16'd0, want.front_skew_mm},
                     {16'd0, out_item.front_skew_mm});
          checked++;
        end
      end
      pending <= expected_walls.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the wall presence hysteresis unit.
// Directed sensor sets cover range extremes, single-sensor front cases,
// skew saturation, invalid runs, a zero run length, a run counter left above
// a lowered limit and inverted thresholds; random phases follow, each under
// new register settings, with sets mostly near the thresholds, some with random
// idle bursts on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wphu_pkg::*;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  wphu_in_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  wphu_out_t           out_item;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int        mismatches, pending, checked, flag_changes;
  int        idle_level = 0;
  int        stall_left = 0;
  int        sets_sent = 0;
  int        settings_used = 0;
  wphu_cfg_t stim_cfg;

  wall_presence_hysteresis_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wphu_checker wall_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .pending(pending), .checked(checked),
    .flag_changes(flag_changes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("testbench failed");
    $finish;
  end

  // result side stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (idle_level != 0 && $urandom_range(0, idle_level == 1 ? 15 : 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 12);
    end
  end

  task automatic reg_access(input logic wr, input wphu_reg_e r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic read_back_and_release();
    reg_access(1'b0, REG_FRONT_DETECT, '0);
    reg_access(1'b0, REG_FRONT_CLEAR, '0);
    reg_access(1'b0, REG_SIDE_DETECT, '0);
    reg_access(1'b0, REG_SIDE_CLEAR, '0);
    reg_access(1'b0, REG_INVALID_RUN, '0);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input wphu_cfg_t c);
    reg_access(1'b1, REG_FRONT_DETECT, {16'd0, c.front_detect_mm});
    reg_access(1'b1, REG_FRONT_CLEAR, {16'd0, c.front_clear_mm});
    reg_access(1'b1, REG_SIDE_DETECT, {16'd0, c.side_detect_mm});
    reg_access(1'b1, REG_SIDE_CLEAR, {16'd0, c.side_clear_mm});
    reg_access(1'b1, REG_INVALID_RUN, {28'd0, c.invalid_run_to_clear});
    read_back_and_release();
    stim_cfg = c;
    settings_used++;
  endtask

  task automatic push_set(input wphu_in_t s);
    int gap;
    gap = 0;
    if (idle_level != 0 && $urandom_range(0, idle_level == 1 ? 15 : 4) == 0) begin
      gap = $urandom_range(1, 12);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sets_sent++;
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (pending != 0 && n < 2000);
    repeat (4) @(posedge clk);
  endtask

  function automatic wphu_in_t mk_set(input logic rdy, input logic [15:0] fl, fr, ls, rs,
                                      input logic fl_ok, fr_ok, ls_ok, rs_ok);
    wphu_in_t s;
    s.sensors_ready = rdy;
    s.front_left_distance = fl;
    s.front_right_distance = fr;
    s.left_side_distance = ls;
    s.right_side_distance = rs;
    s.front_left_ok = fl_ok;
    s.front_right_ok = fr_ok;
    s.left_side_ok = ls_ok;
    s.right_side_ok = rs_ok;
    return s;
  endfunction

  function automatic wphu_cfg_t mk_cfg(input logic [15:0] fd, fc, sd, sc,
                                       input logic [3:0] run);
    wphu_cfg_t c;
    c.front_detect_mm = fd;
    c.front_clear_mm = fc;
    c.side_detect_mm = sd;
    c.side_clear_mm = sc;
    c.invalid_run_to_clear = run;
    return c;
  endfunction

  function automatic logic [15:0] pick_dist(input logic [15:0] near_mark, far_mark);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return near_mark + 16'($urandom_range(0, 8)) - 16'd4;
      4, 5, 6:    return far_mark + 16'($urandom_range(0, 8)) - 16'd4;
      7:          return 16'($urandom_range(0, 65535));
      8:          return 16'($urandom_range(0, 400));
      default:    return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    endcase
  endfunction

  function automatic wphu_in_t random_set(input int bad_pct);
    wphu_in_t s;
    if ($urandom_range(0, 99) < 8) begin
      return mk_set(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom));
    end
    s.sensors_ready = $urandom_range(0, 99) >= 6;
    s.front_left_distance = pick_dist(stim_cfg.front_detect_mm, stim_cfg.front_clear_mm);
    s.front_right_distance = pick_dist(stim_cfg.front_detect_mm, stim_cfg.front_clear_mm);
    s.left_side_distance = pick_dist(stim_cfg.side_detect_mm, stim_cfg.side_clear_mm);
    s.right_side_distance = pick_dist(stim_cfg.side_detect_mm, stim_cfg.side_clear_mm);
    s.front_left_ok = $urandom_range(0, 99) >= bad_pct;
    s.front_right_ok = $urandom_range(0, 99) >= bad_pct;
    s.left_side_ok = $urandom_range(0, 99) >= bad_pct;
    s.right_side_ok = $urandom_range(0, 99) >= bad_pct;
    return s;
  endfunction

  function automatic wphu_cfg_t pick_cfg(input int phase);
    logic [15:0] fd, sd;
    fd = 16'($urandom_range(100, 200));
    sd = 16'($urandom_range(100, 200));
    case (phase == 0 ? 0 : phase == 1 ? 1 : $urandom_range(2, 6))
      0: return mk_cfg(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0);
      1: return mk_cfg(16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'd15);
      2: return mk_cfg(FRONT_DETECT_RST, FRONT_CLEAR_RST, SIDE_DETECT_RST,
                       SIDE_CLEAR_RST, INVALID_RUN_RST);
      3: return mk_cfg(fd, fd + 16'($urandom_range(0, 40)), sd,
                       sd + 16'($urandom_range(0, 40)), 4'($urandom_range(1, 15)));
      4: return mk_cfg(fd, fd - 16'($urandom_range(1, 60)), sd,
                       sd - 16'($urandom_range(1, 60)), 4'($urandom_range(0, 15)));
      5: return mk_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       4'($urandom));
      default: return mk_cfg(fd, fd + 16'($urandom_range(0, 40)), sd,
                             sd + 16'($urandom_range(0, 40)), 4'($urandom_range(1, 4)));
    endcase
  endfunction

  initial begin
    int bad_pct;
    stim_cfg = mk_cfg(FRONT_DETECT_RST, FRONT_CLEAR_RST, SIDE_DETECT_RST,
                      SIDE_CLEAR_RST, INVALID_RUN_RST);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_back_and_release();

    // reset settings: holds, extremes, boundaries, single front sensor, skew limits
    push_set(mk_set(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'd121, 16'd134, 16'd121, 16'd121, 1'b1, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'd135, 16'd135, 16'd122, 16'd122, 1'b1, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'd116, 16'd115, 16'd109, 16'd108, 1'b1, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'd115, 16'hffff, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'd0, 16'd135, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'hffff, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'd0, 16'hffff, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    repeat (3) push_set(mk_set(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    push_set(mk_set(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    drain();

    // zero run length clears on the first invalid sample
    apply_cfg(mk_cfg(FRONT_DETECT_RST, FRONT_CLEAR_RST, SIDE_DETECT_RST,
                     SIDE_CLEAR_RST, 4'd0));
    push_set(mk_set(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    push_set(mk_set(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    drain();

    // run counter left above a lowered limit
    apply_cfg(mk_cfg(FRONT_DETECT_RST, FRONT_CLEAR_RST, SIDE_DETECT_RST,
                     SIDE_CLEAR_RST, 4'd15));
    push_set(mk_set(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    repeat (5) push_set(mk_set(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    drain();
    apply_cfg(mk_cfg(FRONT_DETECT_RST, FRONT_CLEAR_RST, SIDE_DETECT_RST,
                     SIDE_CLEAR_RST, 4'd2));
    push_set(mk_set(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    push_set(mk_set(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    drain();

    // detect above clear
    apply_cfg(mk_cfg(16'd200, 16'd100, 16'd200, 16'd100, 4'd2));
    repeat (2) push_set(mk_set(1'b1, 16'd150, 16'd150, 16'd150, 16'd150,
                               1'b1, 1'b1, 1'b1, 1'b1));
    drain();

    for (int phase = 0; phase < 14; phase++) begin
      idle_level = (phase >= 12) ? 0 : $urandom_range(0, 2);
      apply_cfg(pick_cfg(phase));
      case ($urandom_range(0, 3))
        0:       bad_pct = 85;
        1:       bad_pct = $urandom_range(30, 60);
        default: bad_pct = $urandom_range(2, 20);
      endcase
      repeat (125) push_set(random_set(bad_pct));
      drain();
    end

    $display("%0d sensor sets under %0d register settings, %0d results checked",
             sets_sent, settings_used, checked);
    $display("%0d wall flag changes seen", flag_changes);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wphu_pkg.sv
hdl/wphu_cfg.sv
hdl/wphu_track.sv
hdl/wall_presence_hysteresis_unit.sv
tb/wphu_checker.sv
tb/testbench.sv
